// File: hw/rtl/pgf_pkg.sv
// Package for the pairwise gravity force unit.
// Widths, register codes and the transaction and cell payload types.
// No dependencies.
`default_nettype none

package pgf_pkg;

    localparam int AXES      = 3;
    localparam int SQ_CELLS  = 49;
    localparam int DIV_CELLS = 48;

    localparam int POS_W  = 32;
    localparam int MASS_W = 32;
    localparam int G_W    = 16;
    localparam int GM_W   = 48;
    localparam int MAG_W  = 33;
    localparam int S_W    = 66;
    localparam int V_W    = 98;
    localparam int RF_W   = 49;
    localparam int SQR_W  = 52;
    localparam int P_W    = 80;
    localparam int NP_W   = 113;
    localparam int DEN_W  = 115;
    localparam int Q_W    = 48;
    localparam int F_W    = 48;

    localparam logic [MASS_W-1:0] OWN_MASS_RST = 32'd54525463;
    localparam logic [G_W-1:0]    GRAVITY_RST  = 16'd43739;

    localparam logic [F_W-1:0] F_MAX = {1'b0, {(F_W-1){1'b1}}};
    localparam logic [F_W-1:0] F_MIN = {1'b1, {(F_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_OWN_MASS = 2'd0,
        REG_GRAVITY  = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] own_x;
        logic signed [POS_W-1:0] own_y;
        logic signed [POS_W-1:0] own_z;
        logic signed [POS_W-1:0] other_x;
        logic signed [POS_W-1:0] other_y;
        logic signed [POS_W-1:0] other_z;
        logic [MASS_W-1:0]       other_mass;
        logic                    last_body;
    } t_in_item;

    typedef struct packed {
        logic signed [F_W-1:0] force_x;
        logic signed [F_W-1:0] force_y;
        logic signed [F_W-1:0] force_z;
        logic                  coincident;
        logic                  saturated;
        logic                  last_force;
    } t_out_item;

    typedef struct packed {
        logic                       valid;
        logic [V_W-1:0]             v;
        logic [RF_W-1:0]            root;
        logic [SQR_W-1:0]           rem;
        logic [S_W-1:0]             s;
        logic [AXES-1:0][NP_W-1:0]  nump;
        logic [AXES-1:0]            neg;
        logic                       last;
        logic                       coin;
    } t_sq;

    typedef struct packed {
        logic                       valid;
        logic [DEN_W-1:0]           den;
        logic [AXES-1:0][DEN_W-1:0] rem;
        logic [AXES-1:0][Q_W-1:0]   nlo;
        logic [AXES-1:0][Q_W-1:0]   q;
        logic [AXES-1:0]            big;
        logic [AXES-1:0]            neg;
        logic                       last;
        logic                       coin;
    } t_div;

endpackage

`default_nettype wire

// File: hw/rtl/pgf_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per cycle.
// Depends on pgf_pkg.
`default_nettype none

module pgf_sqrt_cell (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  pgf_pkg::t_sq    i_d,
    output pgf_pkg::t_sq    o_d
);

    pgf_pkg::t_sq r_d;
    pgf_pkg::t_sq n_d;

    logic [pgf_pkg::SQR_W:0] sh;
    logic [pgf_pkg::SQR_W:0] trial;

    always_comb begin
        n_d   = i_d;
        sh    = {i_d.rem[pgf_pkg::SQR_W-2:0], i_d.v[pgf_pkg::V_W-1 -: 2]};
        trial = (pgf_pkg::SQR_W+1)'({i_d.root, 2'b01});
        n_d.v = {i_d.v[pgf_pkg::V_W-3:0], 2'b00};
        if (sh >= trial) begin
            n_d.rem  = pgf_pkg::SQR_W'(sh - trial);
            n_d.root = {i_d.root[pgf_pkg::RF_W-2:0], 1'b1};
        end else begin
            n_d.rem  = pgf_pkg::SQR_W'(sh);
            n_d.root = {i_d.root[pgf_pkg::RF_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

// File: hw/rtl/pgf_div_cell.sv
// One cell of the divider chain: one quotient bit per axis per cycle.
// Depends on pgf_pkg.
`default_nettype none

module pgf_div_cell (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  pgf_pkg::t_div   i_d,
    output pgf_pkg::t_div   o_d
);

    pgf_pkg::t_div r_d;
    pgf_pkg::t_div n_d;

    logic [pgf_pkg::AXES-1:0][pgf_pkg::DEN_W:0] sh;

    always_comb begin
        n_d = i_d;
        for (int k = 0; k < pgf_pkg::AXES; k++) begin
            sh[k]      = {i_d.rem[k], i_d.nlo[k][pgf_pkg::Q_W-1]};
            n_d.nlo[k] = {i_d.nlo[k][pgf_pkg::Q_W-2:0], 1'b0};
            if (sh[k] >= {1'b0, i_d.den}) begin
                n_d.rem[k] = pgf_pkg::DEN_W'(sh[k] - {1'b0, i_d.den});
                n_d.q[k]   = {i_d.q[k][pgf_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_d.rem[k] = pgf_pkg::DEN_W'(sh[k]);
                n_d.q[k]   = {i_d.q[k][pgf_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

// File: hw/rtl/pairwise_gravity_force_unit.sv
// Top level of the pairwise gravity force unit.
// Depends on pgf_pkg, pgf_sqrt_cell and pgf_div_cell.
//
// Usage:
//   Input: a transaction is taken at a clock edge with start high and busy
//   low. busy is always low, so one body pair may enter every cycle.
//   Output: o_valid strobes for one cycle with o_result; the receiver
//   cannot stall, results are never held.
//   Config: i_cfg_valid/o_cfg_ready with i_cfg_index (0 own mass,
//   1 gravity constant) and i_cfg_data; other indexes are ignored.
//   o_cfg_ready is always high. Write only while no pair is in flight.
//   Pipeline: 106 register stages; throughput one pair per cycle. The
//   figure is set by the 49-cell square root chain, the 48-cell divider
//   chain and 9 multiply and setup stages.
//   Reset: clears all valid bits (in-flight pairs are dropped) and loads
//   the register reset values. No clearing pass.
`default_nettype none

module pairwise_gravity_force_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  pgf_pkg::t_in_item           i_item,
    output logic                        o_valid,
    output pgf_pkg::t_out_item          o_result,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  [1:0]                  i_cfg_index,
    input  wire  [pgf_pkg::MASS_W-1:0]  i_cfg_data
);

    localparam int A = pgf_pkg::AXES;

    logic [pgf_pkg::MASS_W-1:0] r_own_mass;
    logic [pgf_pkg::G_W-1:0]    r_gravity;

    logic acc;
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign acc         = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mass <= pgf_pkg::OWN_MASS_RST;
            r_gravity  <= pgf_pkg::GRAVITY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (pgf_pkg::t_reg_idx'(i_cfg_index))
                pgf_pkg::REG_OWN_MASS: r_own_mass <= i_cfg_data;
                pgf_pkg::REG_GRAVITY:  r_gravity  <= i_cfg_data[pgf_pkg::G_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: differences, magnitudes, G * own mass
    logic                                 r1_valid;
    logic [A-1:0][pgf_pkg::MAG_W-1:0]     r1_mag, n1_mag;
    logic [A-1:0]                         r1_neg, n1_neg;
    logic [pgf_pkg::MASS_W-1:0]           r1_om;
    logic [pgf_pkg::GM_W-1:0]             r1_gm;
    logic                                 r1_last;
    logic [A-1:0][pgf_pkg::POS_W-1:0]     own_p, oth_p;
    logic signed [pgf_pkg::MAG_W-1:0]     dif [A];

    always_comb begin
        own_p = {i_item.own_z, i_item.own_y, i_item.own_x};
        oth_p = {i_item.other_z, i_item.other_y, i_item.other_x};
        for (int k = 0; k < A; k++) begin
            dif[k] = $signed({oth_p[k][pgf_pkg::POS_W-1], oth_p[k]})
                   - $signed({own_p[k][pgf_pkg::POS_W-1], own_p[k]});
            n1_neg[k] = dif[k][pgf_pkg::MAG_W-1];
            n1_mag[k] = n1_neg[k] ? pgf_pkg::MAG_W'(-dif[k]) : pgf_pkg::MAG_W'(dif[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_mag  <= n1_mag;
        r1_neg  <= n1_neg;
        r1_om   <= i_item.other_mass;
        r1_last <= i_item.last_body;
        r1_gm   <= pgf_pkg::GM_W'(r_gravity) * pgf_pkg::GM_W'(r_own_mass);
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= acc;
        end
    end

    // stage 2: squares and mass partial products
    logic                               r2_valid;
    logic [A-1:0][pgf_pkg::S_W-1:0]     r2_sq;
    logic [A-1:0][pgf_pkg::MAG_W-1:0]   r2_mag;
    logic [A-1:0]                       r2_neg;
    logic                               r2_last;
    logic [55:0]                        r2_pml, r2_pmh;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < A; k++) begin
            r2_sq[k] <= pgf_pkg::S_W'(r1_mag[k]) * pgf_pkg::S_W'(r1_mag[k]);
        end
        r2_pml  <= 56'(r1_gm[23:0]) * 56'(r1_om);
        r2_pmh  <= 56'(r1_gm[47:24]) * 56'(r1_om);
        r2_mag  <= r1_mag;
        r2_neg  <= r1_neg;
        r2_last <= r1_last;
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    // stage 3: sum of squares, full mass product
    logic                               r3_valid;
    logic [pgf_pkg::S_W-1:0]            r3_s;
    logic [pgf_pkg::P_W-1:0]            r3_p;
    logic [A-1:0][pgf_pkg::MAG_W-1:0]   r3_mag;
    logic [A-1:0]                       r3_neg;
    logic                               r3_last;

    always_ff @(posedge i_clk) begin
        r3_s    <= r2_sq[0] + r2_sq[1] + r2_sq[2];
        r3_p    <= pgf_pkg::P_W'(r2_pml) + (pgf_pkg::P_W'(r2_pmh) << 24);
        r3_mag  <= r2_mag;
        r3_neg  <= r2_neg;
        r3_last <= r2_last;
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    // stage 4: numerator partial products
    logic                               r4_valid;
    logic [A-1:0][2:0][59:0]            r4_pp;
    logic [pgf_pkg::S_W-1:0]            r4_s;
    logic [A-1:0]                       r4_neg;
    logic                               r4_last;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < A; k++) begin
            r4_pp[k][0] <= 60'(r3_p[26:0])  * 60'(r3_mag[k]);
            r4_pp[k][1] <= 60'(r3_p[53:27]) * 60'(r3_mag[k]);
            r4_pp[k][2] <= 60'(r3_p[79:54]) * 60'(r3_mag[k]);
        end
        r4_s    <= r3_s;
        r4_neg  <= r3_neg;
        r4_last <= r3_last;
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    // stage 5: numerators, square root chain entry
    pgf_pkg::t_sq r5_sq, n5_sq;

    always_comb begin
        n5_sq.valid = r4_valid;
        n5_sq.v     = {r4_s, 32'd0};
        n5_sq.root  = '0;
        n5_sq.rem   = '0;
        n5_sq.s     = r4_s;
        n5_sq.neg   = r4_neg;
        n5_sq.last  = r4_last;
        n5_sq.coin  = (r4_s == '0);
        for (int k = 0; k < A; k++) begin
            n5_sq.nump[k] = pgf_pkg::NP_W'(r4_pp[k][0])
                          + (pgf_pkg::NP_W'(r4_pp[k][1]) << 27)
                          + (pgf_pkg::NP_W'(r4_pp[k][2]) << 54);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_sq <= '0;
        end else begin
            r5_sq <= n5_sq;
        end
    end

    pgf_pkg::t_sq sq_link [pgf_pkg::SQ_CELLS+1];
    assign sq_link[0] = r5_sq;

    for (genvar i = 0; i < pgf_pkg::SQ_CELLS; i++) begin : g_sq
        pgf_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (sq_link[i]),
            .o_d     (sq_link[i+1])
        );
    end

    pgf_pkg::t_sq sq_out;
    assign sq_out = sq_link[pgf_pkg::SQ_CELLS];

    // stage D1: denominator partial products
    logic                               r6_valid;
    logic [2:0][1:0][46:0]              r6_pd;
    logic [A-1:0][pgf_pkg::NP_W-1:0]    r6_nump;
    logic [A-1:0]                       r6_neg;
    logic                               r6_last, r6_coin;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r6_pd[a][0] <= 47'(sq_out.s[22*a +: 22]) * 47'(sq_out.root[24:0]);
            r6_pd[a][1] <= 47'(sq_out.s[22*a +: 22]) * 47'(sq_out.root[48:25]);
        end
        r6_nump <= sq_out.nump;
        r6_neg  <= sq_out.neg;
        r6_last <= sq_out.last;
        r6_coin <= sq_out.coin;
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= sq_out.valid;
        end
    end

    // stage D2: denominator sum
    logic                               r7_valid;
    logic [pgf_pkg::DEN_W-1:0]          r7_den, n7_den;
    logic [A-1:0][pgf_pkg::NP_W-1:0]    r7_nump;
    logic [A-1:0]                       r7_neg;
    logic                               r7_last, r7_coin;

    always_comb begin
        n7_den = '0;
        for (int a = 0; a < 3; a++) begin
            n7_den = n7_den + (pgf_pkg::DEN_W'(r6_pd[a][0]) << (22*a))
                            + (pgf_pkg::DEN_W'(r6_pd[a][1]) << (22*a + 25));
        end
    end

    always_ff @(posedge i_clk) begin
        r7_den  <= n7_den;
        r7_nump <= r6_nump;
        r7_neg  <= r6_neg;
        r7_last <= r6_last;
        r7_coin <= r6_coin;
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else begin
            r7_valid <= r6_valid;
        end
    end

    // stage D3: overflow pre-check and divider chain entry
    pgf_pkg::t_div r8_dv, n8_dv;

    always_comb begin
        n8_dv.valid = r7_valid;
        n8_dv.den   = r7_den;
        n8_dv.neg   = r7_neg;
        n8_dv.last  = r7_last;
        n8_dv.coin  = r7_coin;
        for (int k = 0; k < A; k++) begin
            n8_dv.rem[k] = pgf_pkg::DEN_W'(r7_nump[k][pgf_pkg::NP_W-1:24]);
            n8_dv.big[k] = pgf_pkg::DEN_W'(r7_nump[k][pgf_pkg::NP_W-1:24]) >= r7_den;
            n8_dv.nlo[k] = {r7_nump[k][23:0], 24'd0};
            n8_dv.q[k]   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_dv <= '0;
        end else begin
            r8_dv <= n8_dv;
        end
    end

    pgf_pkg::t_div dv_link [pgf_pkg::DIV_CELLS+1];
    assign dv_link[0] = r8_dv;

    for (genvar i = 0; i < pgf_pkg::DIV_CELLS; i++) begin : g_div
        pgf_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (dv_link[i]),
            .o_d     (dv_link[i+1])
        );
    end

    pgf_pkg::t_div dv_out;
    assign dv_out = dv_link[pgf_pkg::DIV_CELLS];

    // output stage: clamp, sign, coincident case
    logic                               r_out_valid;
    pgf_pkg::t_out_item                 r_out, n_out;
    logic [A-1:0][pgf_pkg::F_W-1:0]     frc;
    logic [A-1:0][pgf_pkg::Q_W-1:0]     lim, qv;
    logic [A-1:0]                       clamp;

    always_comb begin
        for (int k = 0; k < A; k++) begin
            lim[k]   = dv_out.neg[k] ? pgf_pkg::F_MIN : pgf_pkg::F_MAX;
            clamp[k] = dv_out.big[k] || (dv_out.q[k] > lim[k]);
            qv[k]    = clamp[k] ? lim[k] : dv_out.q[k];
            frc[k]   = dv_out.neg[k] ? (pgf_pkg::F_W'(0) - qv[k]) : qv[k];
        end
        n_out.last_force = dv_out.last;
        if (dv_out.coin) begin
            n_out.force_x    = '0;
            n_out.force_y    = '0;
            n_out.force_z    = '0;
            n_out.coincident = 1'b1;
            n_out.saturated  = 1'b0;
        end else begin
            n_out.force_x    = frc[0];
            n_out.force_y    = frc[1];
            n_out.force_z    = frc[2];
            n_out.coincident = 1'b0;
            n_out.saturated  = |clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= dv_out.valid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_coin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.coincident) |->
            (o_result.force_x == '0 && o_result.force_y == '0 &&
             o_result.force_z == '0 && !o_result.saturated))
        else $error("coincident result with nonzero force or saturation");

    a_sat_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.saturated) |->
            (o_result.force_x == pgf_pkg::F_MAX || o_result.force_x == pgf_pkg::F_MIN ||
             o_result.force_y == pgf_pkg::F_MAX || o_result.force_y == pgf_pkg::F_MIN ||
             o_result.force_z == pgf_pkg::F_MAX || o_result.force_z == pgf_pkg::F_MIN))
        else $error("saturated result without a clamped component");

    a_pipe_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(dv_out.valid) |-> o_valid)
        else $error("divider output lost before output register");
`endif

endmodule

`default_nettype wire
